[rtl/bqwm_pkg.sv]
package bqwm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CH_W     = 3;
  localparam int COEF_W   = 18;
  localparam int WET_W    = 15;
  localparam int HIST_Y_W = 32;
  localparam int CFG_A_W  = 3;

  // shared multiplier: 33 x 18 signed
  localparam int MUL_A_W  = 33;
  localparam int MUL_B_W  = 18;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  // filter sum of five products stays below 2^50
  localparam int FILT_W   = 52;
  localparam int ACC_W    = 64;
  // low slice of the filter/dry difference used in the split mix product
  localparam int LO_W     = 24;

  localparam int PC_W     = 4;
  localparam logic [PC_W-1:0] STEP_IDLE  = 4'd0;
  localparam logic [PC_W-1:0] STEP_FIRST = 4'd1;

  localparam logic signed [ACC_W-1:0] HIST_Y_MAX = 64'sd2147483647;
  localparam logic signed [ACC_W-1:0] HIST_Y_MIN = -64'sd2147483648;
  localparam logic signed [ACC_W-1:0] OUT_MAX    = 64'sd32767;
  localparam logic signed [ACC_W-1:0] OUT_MIN    = -64'sd32768;

  typedef enum logic [CFG_A_W-1:0] {
    REG_A0  = 3'd0,
    REG_A1  = 3'd1,
    REG_A2  = 3'd2,
    REG_B1  = 3'd3,
    REG_B2  = 3'd4,
    REG_WET = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_A0X,
    MUL_A1X1,
    MUL_A2X2,
    MUL_B1Y1,
    MUL_B2Y2,
    MUL_WLO,
    MUL_WHI
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_NOP,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB,
    ACC_ADD_HI,
    ACC_DIFF,
    ACC_MIX
  } acc_op_t;

  typedef enum logic [1:0] {
    COND_NEXT,
    COND_IN,
    COND_OUT
  } cond_t;

  typedef struct packed {
    mul_sel_t        mul;
    acc_op_t         acc;
    cond_t           cond;
    logic [PC_W-1:0] tgt;
  } uop_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] a0;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic        [WET_W-1:0]  wet;
  } coef_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x1;
    logic signed [SAMPLE_W-1:0] x2;
    logic signed [HIST_Y_W-1:0] y1;
    logic signed [HIST_Y_W-1:0] y2;
  } hist_t;

  // control store; product lands in prod_r in the step after its MUL
  function automatic uop_t ucode(input logic [PC_W-1:0] pc);
    uop_t u;
    u.mul  = MUL_NONE;
    u.acc  = ACC_NOP;
    u.cond = COND_NEXT;
    u.tgt  = STEP_IDLE;
    unique case (pc)
      4'd0: begin
        u.cond = COND_IN;
        u.tgt  = STEP_FIRST;
      end
      4'd1:  u.mul = MUL_A0X;
      4'd2: begin
        u.mul = MUL_A1X1;
        u.acc = ACC_LOAD;
      end
      4'd3: begin
        u.mul = MUL_A2X2;
        u.acc = ACC_ADD;
      end
      4'd4: begin
        u.mul = MUL_B1Y1;
        u.acc = ACC_ADD;
      end
      4'd5: begin
        u.mul = MUL_B2Y2;
        u.acc = ACC_SUB;
      end
      4'd6:  u.acc = ACC_SUB;
      4'd7:  u.acc = ACC_DIFF;
      4'd8:  u.mul = MUL_WLO;
      4'd9: begin
        u.mul = MUL_WHI;
        u.acc = ACC_LOAD;
      end
      4'd10: u.acc = ACC_ADD_HI;
      4'd11: u.acc = ACC_MIX;
      4'd12: begin
        u.cond = COND_OUT;
        u.tgt  = STEP_IDLE;
      end
      default: begin
        u.cond = COND_NEXT;
        u.tgt  = STEP_IDLE;
      end
    endcase
    return u;
  endfunction

endpackage

[rtl/bqwm_mac.sv]
module bqwm_mac
  import bqwm_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  logic                       clk,
  input  uop_t                       uop,
  input  logic signed [SAMPLE_W-1:0] x,
  input  hist_t                      hist,
  input  coef_t                      coef,
  output logic signed [ACC_W-1:0]    acc
);

  // width of (filtered - dry)
  localparam int D_W = FILT_W - FRAC_BITS;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [D_W-1:0]     d_r;

  always_comb begin
    unique case (uop.mul)
      MUL_A0X: begin
        mul_a = MUL_A_W'($signed(x));
        mul_b = coef.a0;
      end
      MUL_A1X1: begin
        mul_a = MUL_A_W'($signed(hist.x1));
        mul_b = coef.a1;
      end
      MUL_A2X2: begin
        mul_a = MUL_A_W'($signed(hist.x2));
        mul_b = coef.a2;
      end
      MUL_B1Y1: begin
        mul_a = MUL_A_W'($signed(hist.y1));
        mul_b = coef.b1;
      end
      MUL_B2Y2: begin
        mul_a = MUL_A_W'($signed(hist.y2));
        mul_b = coef.b2;
      end
      // difference split: unsigned low slice, signed high slice
      MUL_WLO: begin
        mul_a = $signed({{(MUL_A_W-LO_W){1'b0}}, d_r[LO_W-1:0]});
        mul_b = $signed({{(MUL_B_W-WET_W){1'b0}}, coef.wet});
      end
      MUL_WHI: begin
        mul_a = MUL_A_W'($signed(d_r[D_W-1:LO_W]));
        mul_b = $signed({{(MUL_B_W-WET_W){1'b0}}, coef.wet});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    unique case (uop.acc)
      ACC_LOAD:   acc_r <= ACC_W'(prod_r);
      ACC_ADD:    acc_r <= acc_r + ACC_W'(prod_r);
      ACC_SUB:    acc_r <= acc_r - ACC_W'(prod_r);
      ACC_ADD_HI: acc_r <= acc_r + (ACC_W'(prod_r) <<< LO_W);
      ACC_DIFF:   d_r   <= D_W'((acc_r >>> FRAC_BITS) - ACC_W'($signed(x)));
      ACC_MIX:    acc_r <= ACC_W'($signed(x)) + (acc_r >>> FRAC_BITS);
      default: begin
      end
    endcase
  end

  assign acc = acc_r;

endmodule

[rtl/biquad_filter_wet_mix_unit.sv]
// channel | dir | handshake              | payload
// in      | in  | in_tvalid / in_tready  | tdata: sample_in; tuser: channel
// out     | out | out_tvalid / out_tready| tdata: sample_out; tuser: channel_out
// cfg     | in  | cfg_we                 | cfg_addr index, cfg_wdata value
//
// Each word is accepted by the idle step; then 12 microcode steps run seven
// products through the single shared 33x18 multiplier and accumulator.
// Result goes to an output register; the sequencer stalls in its last step
// only while that register is still full. Next word is taken once back idle.
// Reset (rst_n, synchronous) clears coefficients, history valid bits,
// out_tvalid and the sequencer; history of an unwritten channel reads as zero.
module biquad_filter_wet_mix_unit
  import bqwm_pkg::*;
#(
  parameter int MAX_CHANNELS = 8,
  parameter int FRAC_BITS    = 14
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [15:0]         in_tdata,   // [15:0] sample_in
  input  logic [CH_W-1:0]     in_tuser,   // [2:0] channel
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [15:0]         out_tdata,  // [15:0] sample_out
  output logic [CH_W-1:0]     out_tuser,  // [2:0] channel_out
  input  logic                cfg_we,
  input  logic [CFG_A_W-1:0]  cfg_addr,
  input  logic [COEF_W-1:0]   cfg_wdata
);

  localparam int CH_AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic [PC_W-1:0]             pc_r, pc_nxt;
  uop_t                        uop;
  logic signed [SAMPLE_W-1:0]  x_r;
  logic [CH_W-1:0]             ch_r;
  coef_t                       coef_r;
  hist_t                       hist_mem [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0]     hist_vld_r;
  hist_t                       rd_r;
  hist_t                       wr_hist;
  logic                        ch_ok;
  logic [CH_AW-1:0]            ch_idx;
  logic                        in_acc;
  logic                        out_free;
  logic                        commit;
  logic signed [ACC_W-1:0]     acc;
  logic signed [HIST_Y_W-1:0]  y_sat;
  logic signed [SAMPLE_W-1:0]  y_out;
  logic                        out_tvalid_r;
  logic [15:0]                 out_data_r;
  logic [CH_W-1:0]             out_ch_r;

  assign uop      = ucode(pc_r);
  assign in_tready = (uop.cond == COND_IN);
  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_tvalid_r || out_tready;
  assign commit   = (uop.cond == COND_OUT) && out_free;
  assign ch_ok    = (int'(ch_r) < MAX_CHANNELS);
  assign ch_idx   = CH_AW'(ch_r);

  always_comb begin
    unique case (uop.cond)
      COND_IN:  pc_nxt = in_acc ? uop.tgt : pc_r;
      COND_OUT: pc_nxt = out_free ? uop.tgt : pc_r;
      default:  pc_nxt = PC_W'(pc_r + 1'b1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r  <= $signed(in_tdata);
      ch_r <= in_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_A0:  coef_r.a0  <= $signed(cfg_wdata);
        REG_A1:  coef_r.a1  <= $signed(cfg_wdata);
        REG_A2:  coef_r.a2  <= $signed(cfg_wdata);
        REG_B1:  coef_r.b1  <= $signed(cfg_wdata);
        REG_B2:  coef_r.b2  <= $signed(cfg_wdata);
        REG_WET: coef_r.wet <= cfg_wdata[WET_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // history store: registered read at the current channel every cycle
  always_ff @(posedge clk) begin
    rd_r <= (ch_ok && hist_vld_r[ch_idx]) ? hist_mem[ch_idx] : '0;
    if (commit && ch_ok) begin
      hist_mem[ch_idx] <= wr_hist;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_vld_r <= '0;
    end else if (commit && ch_ok) begin
      hist_vld_r[ch_idx] <= 1'b1;
    end
  end

  bqwm_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk  (clk),
    .uop  (uop),
    .x    (x_r),
    .hist (rd_r),
    .coef (coef_r),
    .acc  (acc)
  );

  always_comb begin
    priority if (acc > HIST_Y_MAX) begin
      y_sat = HIST_Y_W'(HIST_Y_MAX);
    end else if (acc < HIST_Y_MIN) begin
      y_sat = HIST_Y_W'(HIST_Y_MIN);
    end else begin
      y_sat = HIST_Y_W'(acc);
    end
    priority if (acc > OUT_MAX) begin
      y_out = SAMPLE_W'(OUT_MAX);
    end else if (acc < OUT_MIN) begin
      y_out = SAMPLE_W'(OUT_MIN);
    end else begin
      y_out = SAMPLE_W'(acc);
    end
    wr_hist.x1 = x_r;
    wr_hist.x2 = rd_r.x1;
    wr_hist.y1 = y_sat;
    wr_hist.y2 = rd_r.y1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (commit) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_data_r <= y_out;
      out_ch_r   <= ch_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_ch_r;

endmodule
